### src/ehs_pkg.sv
// Shared types and constants for the endstop homing sequencer.
package ehs_pkg;

  localparam int MASK_W  = 3;
  localparam int STEP_W  = 24;
  localparam int PHASE_W = 3;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 3;
  localparam int LIMIT_W = 16;

  // Sequence phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_FAST    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_RETRACT = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SLOW    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TRIM    = 3'd4;

  // Input word action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOME_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETRACT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RETRACT_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RETRACT_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_X    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_Y    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_Z    = 3'd7;

  typedef struct packed {
    logic              action;
    logic [MASK_W-1:0] axes_mask;
    logic [MASK_W-1:0] endstop_min;
    logic [MASK_W-1:0] endstop_max;
    logic [MASK_W-1:0] axis_moving;
  } cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0]  stop_mask;
    logic [MASK_W-1:0]  start_mask;
    logic [MASK_W-1:0]  dir_mask;
    logic               slow_speed;
    logic [STEP_W-1:0]  steps_x;
    logic [STEP_W-1:0]  steps_y;
    logic [STEP_W-1:0]  steps_z;
    logic [PHASE_W-1:0] phase;
    logic               done_res;
  } res_t;

endpackage

### src/ehs_cmd_if.sv
// Input channel: valid/ready handshake carrying one command word.
interface ehs_cmd_if;
  import ehs_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [MASK_W-1:0] axes_mask;
  logic [MASK_W-1:0] endstop_min;
  logic [MASK_W-1:0] endstop_max;
  logic [MASK_W-1:0] axis_moving;

  modport source (output valid, action, axes_mask, endstop_min, endstop_max, axis_moving,
                  input ready);
  modport sink (input valid, action, axes_mask, endstop_min, endstop_max, axis_moving,
                output ready);
endinterface

### src/ehs_res_if.sv
// Output channel: valid/ready handshake carrying one result word.
interface ehs_res_if;
  import ehs_pkg::*;

  logic               valid;
  logic               ready;
  logic [MASK_W-1:0]  stop_mask;
  logic [MASK_W-1:0]  start_mask;
  logic [MASK_W-1:0]  dir_mask;
  logic               slow_speed;
  logic [STEP_W-1:0]  steps_x;
  logic [STEP_W-1:0]  steps_y;
  logic [STEP_W-1:0]  steps_z;
  logic [PHASE_W-1:0] phase;
  logic               done_res;

  modport source (output valid, stop_mask, start_mask, dir_mask, slow_speed,
                  steps_x, steps_y, steps_z, phase, done_res,
                  input ready);
  modport sink (input valid, stop_mask, start_mask, dir_mask, slow_speed,
                steps_x, steps_y, steps_z, phase, done_res,
                output ready);
endinterface

### src/endstop_homing_sequencer_core.sv
// Top level: three-axis endstop homing sequencer (input reg, one logic pass, result reg).
// An accepted word is registered in the input reg, then in the result reg, and can be
//   taken from the result reg.
// Throughput: one word per cycle while the sink keeps res.ready high; the only loop is the
//   phase/counter update in the result stage.
// Reset (rst, synchronous): phase idle, no axes latched, counters zero, both stages empty,
//   registers at min-side mask 7, debounce 100, backoff 400/400/1600, trim 0.
module endstop_homing_sequencer_core #(
  parameter int AXIS_COUNT     = 3,
  parameter int DEBOUNCE_BITS  = 16,
  parameter int APPROACH_STEPS = 10000000
) (
  input  logic                    clk,
  input  logic                    rst,
  ehs_cmd_if.sink                 cmd,
  ehs_res_if.source               res,
  input  logic                    cfg_we,
  input  logic [ehs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ehs_pkg::CFG_W-1:0]     cfg_data
);
  import ehs_pkg::*;

  // Only three axes have fields; extra axes beyond that are not used.
  localparam int AXES_USED = (AXIS_COUNT < 3) ? AXIS_COUNT : 3;
  localparam logic [MASK_W-1:0] AXES_MASK = MASK_W'((1 << AXES_USED) - 1);
  // Compare width covers both the register and the counter.
  localparam int CW = (DEBOUNCE_BITS > LIMIT_W) ? DEBOUNCE_BITS : LIMIT_W;
  localparam logic [CW-1:0] CNT_MAX = CW'((64'd1 << DEBOUNCE_BITS) - 64'd1);
  localparam logic [STEP_W-1:0] APPROACH = STEP_W'(APPROACH_STEPS);

  // ---------------- configuration registers ----------------
  logic [MASK_W-1:0]        min_side_mask;
  logic [LIMIT_W-1:0]       debounce_limit;
  logic [CFG_W-1:0]         backoff_steps [3];
  logic signed [CFG_W-1:0]  trim_steps [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_side_mask    <= 3'd7;
      debounce_limit   <= 16'd100;
      backoff_steps[0] <= 20'd400;
      backoff_steps[1] <= 20'd400;
      backoff_steps[2] <= 20'd1600;
      trim_steps[0]    <= '0;
      trim_steps[1]    <= '0;
      trim_steps[2]    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOME_MIN:  min_side_mask    <= cfg_data[MASK_W-1:0];
        REG_DEBOUNCE:  debounce_limit   <= cfg_data[LIMIT_W-1:0];
        REG_RETRACT_X: backoff_steps[0] <= cfg_data;
        REG_RETRACT_Y: backoff_steps[1] <= cfg_data;
        REG_RETRACT_Z: backoff_steps[2] <= cfg_data;
        REG_TRIM_X:    trim_steps[0]    <= cfg_data;
        REG_TRIM_Y:    trim_steps[1]    <= cfg_data;
        REG_TRIM_Z:    trim_steps[2]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- handshake and stage registers ----------------
  // s1 holds the accepted word; the result register decouples the sink.
  logic s1_valid;
  cmd_t s1_cmd;
  logic res_valid;
  res_t res_word;
  logic res_free;
  logic s1_take;

  assign res_free  = !res_valid || res.ready;
  assign s1_take   = s1_valid && res_free;
  assign cmd.ready = !s1_valid || res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_cmd.action      <= cmd.action;
      s1_cmd.axes_mask   <= cmd.axes_mask;
      s1_cmd.endstop_min <= cmd.endstop_min;
      s1_cmd.endstop_max <= cmd.endstop_max;
      s1_cmd.axis_moving <= cmd.axis_moving;
    end
  end

  // ---------------- sequencer state ----------------
  logic [PHASE_W-1:0]       phase_reg, phase_reg_next;
  logic [MASK_W-1:0]        active_axes, active_axes_next;
  logic [DEBOUNCE_BITS-1:0] debounce_counter [AXES_USED];
  logic [DEBOUNCE_BITS-1:0] debounce_counter_next [AXES_USED];
  res_t                     res_next;

  // Effective limit saturates at the counter's maximum.
  logic [CW-1:0] limit_ext;
  logic [CW-1:0] limit_eff;
  assign limit_ext = CW'(debounce_limit);
  assign limit_eff = (limit_ext < CNT_MAX) ? limit_ext : CNT_MAX;

  // Approach tick: per-axis debounce on the homing-side switch.
  logic [AXES_USED-1:0]     running;
  logic [MASK_W-1:0]        tick_stop;
  logic [DEBOUNCE_BITS-1:0] tick_cnt [AXES_USED];
  logic                     all_homed;

  always_comb begin
    tick_stop = '0;
    for (int c = 0; c < AXES_USED; c++) begin
      logic hit;
      hit = min_side_mask[c] ? s1_cmd.endstop_min[c] : s1_cmd.endstop_max[c];
      tick_cnt[c] = debounce_counter[c];
      running[c]  = 1'b0;
      if (active_axes[c]) begin
        if (hit) begin
          if (CW'(debounce_counter[c]) < limit_eff) begin
            tick_cnt[c] = debounce_counter[c] + DEBOUNCE_BITS'(1);
            running[c]  = 1'b1;
          end else if (s1_cmd.axis_moving[c]) begin
            tick_stop[c] = 1'b1;
          end
        end else begin
          tick_cnt[c] = '0;
          running[c]  = 1'b1;
        end
      end
    end
    all_homed = (running == '0);
  end

  // Trim moves: magnitude and direction per axis, nonzero trims only.
  logic [MASK_W-1:0] trim_mask;
  logic [MASK_W-1:0] trim_dir;
  logic [STEP_W-1:0] trim_mag [3];

  always_comb begin
    trim_mask = '0;
    trim_dir  = '0;
    for (int c = 0; c < 3; c++) begin
      logic signed [STEP_W-1:0] t_ext;
      t_ext       = STEP_W'(trim_steps[c]);
      trim_mag[c] = '0;
      if (c < AXES_USED && active_axes[c] && trim_steps[c] != '0) begin
        trim_mask[c] = 1'b1;
        if (trim_steps[c][CFG_W-1]) begin
          trim_mag[c] = -t_ext;
          trim_dir[c] = !min_side_mask[c];
        end else begin
          trim_mag[c] = t_ext;
          trim_dir[c] = min_side_mask[c];
        end
      end
    end
  end

  // Main next-state and result logic for the word in s1.
  always_comb begin
    logic [STEP_W-1:0] steps [3];
    logic [MASK_W-1:0] start_axes;
    phase_reg_next   = phase_reg;
    active_axes_next = active_axes;
    for (int c = 0; c < AXES_USED; c++) begin
      debounce_counter_next[c] = debounce_counter[c];
    end
    res_next   = '0;
    steps[0]   = '0;
    steps[1]   = '0;
    steps[2]   = '0;
    start_axes = s1_cmd.axes_mask & AXES_MASK;

    if (s1_cmd.action == ACT_START) begin
      if (phase_reg == PH_IDLE) begin
        // Fast approach toward the homing switch.
        active_axes_next    = start_axes;
        phase_reg_next      = PH_FAST;
        res_next.start_mask = start_axes;
        res_next.dir_mask   = min_side_mask & start_axes;
        for (int c = 0; c < AXES_USED; c++) begin
          if (start_axes[c]) steps[c] = APPROACH;
          debounce_counter_next[c] = '0;
        end
      end
    end else begin
      unique case (phase_reg)
        PH_IDLE: ;
        PH_FAST: begin
          for (int c = 0; c < AXES_USED; c++) debounce_counter_next[c] = tick_cnt[c];
          res_next.stop_mask = tick_stop;
          if (all_homed) begin
            // Back off at slow rate, away from home.
            phase_reg_next      = PH_RETRACT;
            res_next.start_mask = active_axes;
            res_next.dir_mask   = ~min_side_mask & active_axes;
            res_next.slow_speed = 1'b1;
            for (int c = 0; c < AXES_USED; c++) begin
              if (active_axes[c]) steps[c] = STEP_W'(backoff_steps[c]);
            end
          end
        end
        PH_RETRACT: begin
          if ((s1_cmd.axis_moving & active_axes) == '0) begin
            phase_reg_next      = PH_SLOW;
            res_next.start_mask = active_axes;
            res_next.dir_mask   = min_side_mask & active_axes;
            res_next.slow_speed = 1'b1;
            for (int c = 0; c < AXES_USED; c++) begin
              if (active_axes[c]) steps[c] = APPROACH;
              debounce_counter_next[c] = '0;
            end
          end
        end
        PH_SLOW: begin
          for (int c = 0; c < AXES_USED; c++) debounce_counter_next[c] = tick_cnt[c];
          res_next.stop_mask = tick_stop;
          if (all_homed) begin
            if (trim_mask == '0) begin
              phase_reg_next    = PH_IDLE;
              active_axes_next  = '0;
              res_next.done_res = 1'b1;
            end else begin
              phase_reg_next      = PH_TRIM;
              res_next.start_mask = trim_mask;
              res_next.dir_mask   = trim_dir;
              res_next.slow_speed = 1'b1;
              steps = trim_mag;
            end
          end
        end
        PH_TRIM: begin
          if ((s1_cmd.axis_moving & active_axes) == '0) begin
            phase_reg_next    = PH_IDLE;
            active_axes_next  = '0;
            res_next.done_res = 1'b1;
          end
        end
        default: phase_reg_next = PH_IDLE;
      endcase
    end

    res_next.steps_x = steps[0];
    res_next.steps_y = steps[1];
    res_next.steps_z = steps[2];
    res_next.phase   = phase_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= PH_IDLE;
      active_axes <= '0;
      for (int c = 0; c < AXES_USED; c++) debounce_counter[c] <= '0;
    end else if (s1_take) begin
      phase_reg   <= phase_reg_next;
      active_axes <= active_axes_next;
      for (int c = 0; c < AXES_USED; c++) debounce_counter[c] <= debounce_counter_next[c];
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) res_word <= res_next;
  end

  assign res.valid      = res_valid;
  assign res.stop_mask  = res_word.stop_mask;
  assign res.start_mask = res_word.start_mask;
  assign res.dir_mask   = res_word.dir_mask;
  assign res.slow_speed = res_word.slow_speed;
  assign res.steps_x    = res_word.steps_x;
  assign res.steps_y    = res_word.steps_y;
  assign res.steps_z    = res_word.steps_z;
  assign res.phase      = res_word.phase;
  assign res.done_res   = res_word.done_res;

  // ---------------- assertions ----------------
  // Idle never keeps latched axes.
  a_idle_no_axes: assert property (@(posedge clk) disable iff (rst)
    phase_reg == PH_IDLE |-> active_axes == '0)
    else $error("axes latched while idle");

  // Latched axes stay within the implemented set.
  a_axes_in_range: assert property (@(posedge clk) disable iff (rst)
    (active_axes & ~AXES_MASK) == '0)
    else $error("axis outside implemented set");

  // A completion word always reports idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.done_res |-> res_word.phase == PH_IDLE)
    else $error("done reported outside idle");

  // A fast move can only start the fast approach.
  a_fast_start: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.start_mask != '0 && !res_word.slow_speed
      |-> res_word.phase == PH_FAST)
    else $error("fast move outside fast approach");

  // A word in s1 with a free result stage moves on in the next cycle.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_free |=> res_valid)
    else $error("result stage did not load");

endmodule
